[src/lws_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lws_pkg;

   // Fixed widths of the statistics words
   localparam int SUM_BITS       = 64;
   localparam int CNT_BITS       = 32;
   localparam int ROOT_BITS      = 32;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 48;

   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   // Register map
   localparam csr_index_type CSR_PERIOD_COUNT   = 2'd0;
   localparam csr_index_type CSR_PERIOD_TIME_US = 2'd1;
   localparam csr_index_type CSR_START_TIME_US  = 2'd2;

   // Report kinds
   localparam logic KIND_PERIOD = 1'b0;
   localparam logic KIND_TOTAL  = 1'b1;

endpackage

`default_nettype wire

[src/lws_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface lws_req_if #(
   parameter int LAT_W  = 24,
   parameter int TIME_W = 48
);
   logic              valid;
   logic              ready;
   logic [LAT_W-1:0]  latency_us;
   logic [TIME_W-1:0] next_time_us;
   logic              final_req;

   modport source (output valid, latency_us, next_time_us, final_req, input ready);
   modport sink (input valid, latency_us, next_time_us, final_req, output ready);
endinterface

`default_nettype wire

[src/lws_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface lws_rsp_if #(
   parameter int LAT_W = 24
);
   logic             valid;
   logic             ready;
   logic             report_kind;
   logic [31:0]      sample_count;
   logic [63:0]      latency_sum;
   logic [LAT_W-1:0] latency_min;
   logic [LAT_W-1:0] latency_max;
   logic [LAT_W-1:0] latency_mean;
   logic [LAT_W-1:0] latency_dev;
   logic             last_of_run;

   modport source (output valid, report_kind, sample_count, latency_sum, latency_min,
      latency_max, latency_mean, latency_dev, last_of_run, input ready);
   modport sink (input valid, report_kind, sample_count, latency_sum, latency_min,
      latency_max, latency_mean, latency_dev, last_of_run, output ready);
endinterface

`default_nettype wire

[src/lws_csr_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface lws_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [47:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[src/latency_window_statistics_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel    Dir  Handshake      Payload
// req_chan   in   valid/ready    latency_us, next_time_us, final_req
// rsp_chan   out  valid/ready    report_kind .. last_of_run (one report per transfer)
// csr_chan   in   valid/ready    index, data (always ready)
//
// One item at a time: each report is built with two 64-step divider passes
// and a 32-step root. A time-based close adds one more 64-step divider pass
// for the deadline.
// Reset is synchronous and clears the statistics, configuration and control registers.
// A report waits in the output register; the sequencer stalls only when it
// has a second report and the first has not been taken.
module latency_window_statistics_top
   import lws_pkg::*;
#(
   parameter int LATENCY_BITS = 24,
   parameter int TIME_BITS    = 48
) (
   input  logic     clock,
   input  logic     reset,
   lws_req_if.sink  req_chan,
   lws_rsp_if.source rsp_chan,
   lws_csr_if.sink  csr_chan
);
   localparam int LW = LATENCY_BITS;
   localparam int TW = TIME_BITS;
   localparam logic [LW-1:0]       LAT_MAX   = '1;
   localparam logic [TW-1:0]       TIME_CEIL = '1;
   localparam logic [CNT_BITS-1:0] CNT_MAX   = '1;
   localparam logic [SUM_BITS-1:0] SUM_MAX   = '1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL, ST_ACC, ST_CHK, ST_MEAN, ST_MS, ST_SQM, ST_SQS,
      ST_SQW, ST_EMIT, ST_FOLDP, ST_ADV, ST_FOLDT, ST_CLEAR
   } state_type;

   state_type state_ff;

   // Configuration
   logic [CNT_BITS-1:0] pcount_ff;
   logic [CNT_BITS-1:0] ptime_ff;
   logic [TW-1:0]       start_ff;

   // Captured item
   logic [LW-1:0] lat_ff;
   logic [TW-1:0] next_ff;
   logic          fin_ff;

   // Statistics
   logic [CNT_BITS-1:0] w_cnt_ff, r_cnt_ff;
   logic [SUM_BITS-1:0] w_sum_ff, r_sum_ff;
   logic [SUM_BITS-1:0] w_sq_ff, r_sq_ff;
   logic [LW-1:0]       w_low_ff, r_low_ff;
   logic [LW-1:0]       w_high_ff, r_high_ff;
   logic [TW-1:0]       deadline_ff;
   logic                started_ff;

   // Report work
   logic                kind_ff;
   logic                adv_ff;
   logic [2*LW-1:0]     prod_ff;
   logic [LW-1:0]       mean_ff;
   logic [SUM_BITS-1:0] ms_ff;
   logic [LW-1:0]       dev_ff;
   logic                div_start_ff;
   logic                sqrt_start_ff;

   // Output register
   logic                rsp_valid_ff;
   logic                o_kind_ff;
   logic [CNT_BITS-1:0] o_cnt_ff;
   logic [SUM_BITS-1:0] o_sum_ff;
   logic [LW-1:0]       o_min_ff, o_max_ff, o_mean_ff, o_dev_ff;
   logic                o_last_ff;

   logic                 div_done;
   logic [SUM_BITS-1:0]  div_quo;
   logic [CNT_BITS-1:0]  div_rem;
   logic [SUM_BITS-1:0]  div_dividend;
   logic [CNT_BITS-1:0]  div_divisor;
   logic                 sqrt_done;
   logic [ROOT_BITS-1:0] sqrt_root;
   logic [SUM_BITS-1:0]  radicand;

   logic [LW-1:0]       mul_a;
   logic [2*LW-1:0]     prod_in;
   logic [CNT_BITS-1:0] w_cnt_inc;
   logic [SUM_BITS:0]   w_sum_add, w_sq_add;
   logic [CNT_BITS:0]   f_cnt_add;
   logic [SUM_BITS:0]   f_sum_add, f_sq_add;
   logic [TW:0]         load_add, adv_add;
   logic [TW-1:0]       diff, base;
   logic                adv_now, close_now;
   logic [CNT_BITS-1:0] src_cnt;
   logic [SUM_BITS-1:0] src_sum, src_sq;
   logic [LW-1:0]       src_low, src_high;
   logic [LW-1:0]       mean_in, dev_in;
   logic                out_free, do_fold, req_acc, rsp_acc, emit_now;

   assign req_acc  = req_chan.valid && req_chan.ready;
   assign rsp_acc  = rsp_valid_ff && rsp_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign emit_now = (state_ff == ST_EMIT) && out_free;

   // Shared multiplier: latency square, then mean square
   assign mul_a   = (state_ff == ST_MUL) ? lat_ff : mean_ff;
   assign prod_in = (2*LW)'(mul_a) * (2*LW)'(mul_a);

   // Window accumulate, saturating
   assign w_cnt_inc = (w_cnt_ff == CNT_MAX) ? w_cnt_ff : w_cnt_ff + 1'b1;
   assign w_sum_add = {1'b0, w_sum_ff} + (SUM_BITS+1)'(lat_ff);
   assign w_sq_add  = {1'b0, w_sq_ff} + (SUM_BITS+1)'(prod_ff);

   // Fold window into run, saturating
   assign f_cnt_add = {1'b0, r_cnt_ff} + {1'b0, w_cnt_ff};
   assign f_sum_add = {1'b0, r_sum_ff} + {1'b0, w_sum_ff};
   assign f_sq_add  = {1'b0, r_sq_ff} + {1'b0, w_sq_ff};

   // Period close and deadline arithmetic
   assign adv_now   = (ptime_ff != '0) && (next_ff >= deadline_ff);
   assign close_now = ((pcount_ff != '0) && (w_cnt_ff >= pcount_ff)) || adv_now;
   assign load_add  = {1'b0, start_ff} + (TW+1)'(ptime_ff);
   assign diff      = next_ff - deadline_ff;
   assign base      = next_ff - TW'(div_rem);
   assign adv_add   = {1'b0, base} + (TW+1)'(ptime_ff);

   // Report source
   assign src_cnt  = (kind_ff == KIND_TOTAL) ? r_cnt_ff : w_cnt_ff;
   assign src_sum  = (kind_ff == KIND_TOTAL) ? r_sum_ff : w_sum_ff;
   assign src_sq   = (kind_ff == KIND_TOTAL) ? r_sq_ff : w_sq_ff;
   assign src_low  = (kind_ff == KIND_TOTAL) ? r_low_ff : w_low_ff;
   assign src_high = (kind_ff == KIND_TOTAL) ? r_high_ff : w_high_ff;

   always_comb begin
      case (state_ff)
         ST_MEAN: begin
            div_dividend = src_sum;
            div_divisor  = src_cnt;
         end
         ST_MS: begin
            div_dividend = src_sq;
            div_divisor  = src_cnt;
         end
         default: begin
            div_dividend = SUM_BITS'(diff);
            div_divisor  = ptime_ff;
         end
      endcase
   end

   assign mean_in  = (div_quo > SUM_BITS'(LAT_MAX)) ? LAT_MAX : div_quo[LW-1:0];
   assign dev_in   = (sqrt_root > ROOT_BITS'(LAT_MAX)) ? LAT_MAX : sqrt_root[LW-1:0];
   assign radicand = (ms_ff > SUM_BITS'(prod_ff)) ? ms_ff - SUM_BITS'(prod_ff) : '0;
   assign do_fold  = (state_ff == ST_FOLDP) || (state_ff == ST_FOLDT);

   lws_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start_ff),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   lws_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start_ff),
      .radicand (radicand),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   // Sequencer, statistics and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pcount_ff     <= '0;
         ptime_ff      <= '0;
         start_ff      <= '0;
         w_cnt_ff      <= '0;
         w_sum_ff      <= '0;
         w_sq_ff       <= '0;
         w_low_ff      <= LAT_MAX;
         w_high_ff     <= '0;
         r_cnt_ff      <= '0;
         r_sum_ff      <= '0;
         r_sq_ff       <= '0;
         r_low_ff      <= LAT_MAX;
         r_high_ff     <= '0;
         deadline_ff   <= '0;
         started_ff    <= 1'b0;
         kind_ff       <= KIND_PERIOD;
         adv_ff        <= 1'b0;
         div_start_ff  <= 1'b0;
         sqrt_start_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         div_start_ff  <= 1'b0;
         sqrt_start_ff <= 1'b0;

         // Configuration transfer
         if (csr_chan.valid) begin
            case (csr_chan.index)
               CSR_PERIOD_COUNT:   pcount_ff <= csr_chan.data[CNT_BITS-1:0];
               CSR_PERIOD_TIME_US: ptime_ff  <= csr_chan.data[CNT_BITS-1:0];
               CSR_START_TIME_US:  start_ff  <= TW'(csr_chan.data);
               default: ;
            endcase
         end

         // Output valid: load a new report, or drop the one just taken
         if (emit_now) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_acc) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_acc) begin
                  lat_ff   <= req_chan.latency_us;
                  next_ff  <= req_chan.next_time_us;
                  fin_ff   <= req_chan.final_req;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               prod_ff <= prod_in;
               if (!started_ff) begin
                  deadline_ff <= load_add[TW] ? TIME_CEIL : load_add[TW-1:0];
                  started_ff  <= 1'b1;
               end
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               w_cnt_ff <= w_cnt_inc;
               w_sum_ff <= w_sum_add[SUM_BITS] ? SUM_MAX : w_sum_add[SUM_BITS-1:0];
               w_sq_ff  <= w_sq_add[SUM_BITS] ? SUM_MAX : w_sq_add[SUM_BITS-1:0];
               if (lat_ff < w_low_ff) begin
                  w_low_ff <= lat_ff;
               end
               if (lat_ff > w_high_ff) begin
                  w_high_ff <= lat_ff;
               end
               state_ff <= ST_CHK;
            end
            ST_CHK: begin
               adv_ff <= adv_now;
               if (close_now) begin
                  kind_ff      <= KIND_PERIOD;
                  div_start_ff <= 1'b1;
                  state_ff     <= ST_MEAN;
               end else if (fin_ff) begin
                  state_ff <= ST_FOLDT;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_MEAN: begin
               if (div_done) begin
                  mean_ff      <= mean_in;
                  div_start_ff <= 1'b1;
                  state_ff     <= ST_MS;
               end
            end
            ST_MS: begin
               if (div_done) begin
                  ms_ff    <= div_quo;
                  state_ff <= ST_SQM;
               end
            end
            ST_SQM: begin
               prod_ff  <= prod_in;
               state_ff <= ST_SQS;
            end
            ST_SQS: begin
               sqrt_start_ff <= 1'b1;
               state_ff      <= ST_SQW;
            end
            ST_SQW: begin
               if (sqrt_done) begin
                  dev_ff   <= dev_in;
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  o_kind_ff    <= kind_ff;
                  o_cnt_ff     <= src_cnt;
                  o_sum_ff     <= src_sum;
                  o_min_ff     <= src_low;
                  o_max_ff     <= src_high;
                  o_mean_ff    <= mean_ff;
                  o_dev_ff     <= dev_ff;
                  o_last_ff    <= (kind_ff == KIND_TOTAL) || !fin_ff;
                  state_ff     <= (kind_ff == KIND_TOTAL) ? ST_CLEAR : ST_FOLDP;
               end
            end
            ST_FOLDP: begin
               if (adv_ff) begin
                  div_start_ff <= 1'b1;
                  state_ff     <= ST_ADV;
               end else begin
                  state_ff <= fin_ff ? ST_FOLDT : ST_IDLE;
               end
            end
            ST_ADV: begin
               if (div_done) begin
                  deadline_ff <= adv_add[TW] ? TIME_CEIL : adv_add[TW-1:0];
                  state_ff    <= fin_ff ? ST_FOLDT : ST_IDLE;
               end
            end
            ST_FOLDT: begin
               kind_ff      <= KIND_TOTAL;
               div_start_ff <= 1'b1;
               state_ff     <= ST_MEAN;
            end
            ST_CLEAR: begin
               r_cnt_ff    <= '0;
               r_sum_ff    <= '0;
               r_sq_ff     <= '0;
               r_low_ff    <= LAT_MAX;
               r_high_ff   <= '0;
               deadline_ff <= '0;
               started_ff  <= 1'b0;
               state_ff    <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase

         // Fold the window into the run totals and reopen the window
         if (do_fold) begin
            r_cnt_ff  <= f_cnt_add[CNT_BITS] ? CNT_MAX : f_cnt_add[CNT_BITS-1:0];
            r_sum_ff  <= f_sum_add[SUM_BITS] ? SUM_MAX : f_sum_add[SUM_BITS-1:0];
            r_sq_ff   <= f_sq_add[SUM_BITS] ? SUM_MAX : f_sq_add[SUM_BITS-1:0];
            if (w_low_ff < r_low_ff) begin
               r_low_ff <= w_low_ff;
            end
            if (w_high_ff > r_high_ff) begin
               r_high_ff <= w_high_ff;
            end
            w_cnt_ff  <= '0;
            w_sum_ff  <= '0;
            w_sq_ff   <= '0;
            w_low_ff  <= LAT_MAX;
            w_high_ff <= '0;
         end
      end
   end

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.report_kind  = o_kind_ff;
   assign rsp_chan.sample_count = o_cnt_ff;
   assign rsp_chan.latency_sum  = o_sum_ff;
   assign rsp_chan.latency_min  = o_min_ff;
   assign rsp_chan.latency_max  = o_max_ff;
   assign rsp_chan.latency_mean = o_mean_ff;
   assign rsp_chan.latency_dev  = o_dev_ff;
   assign rsp_chan.last_of_run  = o_last_ff;

   // Divider results only arrive while the sequencer waits for them
   a_div_done_waiting: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_MEAN || state_ff == ST_MS || state_ff == ST_ADV))
      else $error("divider finished outside a wait state");

   // An accepted item blocks the next one
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_chan.ready)
      else $error("second item taken while one is in work");

   // A report never overwrites one that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |=> rsp_valid_ff)
      else $error("waiting report lost");

   // A filled window keeps low at or below high
   a_window_order: assert property (@(posedge clock) disable iff (reset)
      (w_cnt_ff != '0) |-> (w_low_ff <= w_high_ff))
      else $error("window extremes out of order");

   // Nothing is counted before a run starts
   a_empty_before_start: assert property (@(posedge clock) disable iff (reset)
      !started_ff |-> (w_cnt_ff == '0 && r_cnt_ff == '0))
      else $error("statistics present before run start");
endmodule

`default_nettype wire

[src/lws_div.sv]
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle
module lws_div
   import lws_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [SUM_BITS-1:0] dividend,
   input  logic [CNT_BITS-1:0] divisor,
   output logic                done,
   output logic [SUM_BITS-1:0] quotient,
   output logic [CNT_BITS-1:0] remainder
);
   localparam int STEP_W = $clog2(SUM_BITS);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_BITS - 1);

   logic [SUM_BITS-1:0] quo_ff;
   logic [CNT_BITS-1:0] rem_ff;
   logic [CNT_BITS-1:0] dsr_ff;
   logic [STEP_W-1:0]   step_ff;
   logic                busy_ff;
   logic                done_ff;

   logic [CNT_BITS:0] trial;
   logic [CNT_BITS:0] diff;
   logic              fits;

   // Shift in the next dividend bit and try the subtract
   assign trial = {rem_ff, quo_ff[SUM_BITS-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            quo_ff  <= dividend;
            rem_ff  <= '0;
            dsr_ff  <= divisor;
            step_ff <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            quo_ff  <= {quo_ff[SUM_BITS-2:0], fits};
            rem_ff  <= fits ? diff[CNT_BITS-1:0] : trial[CNT_BITS-1:0];
            step_ff <= step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule

`default_nettype wire

[src/lws_sqrt.sv]
`timescale 1ns / 1ps
`default_nettype none

// Digit-by-digit integer square root, two radicand bits per cycle
module lws_sqrt
   import lws_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [SUM_BITS-1:0]  radicand,
   output logic                 done,
   output logic [ROOT_BITS-1:0] root
);
   localparam int STEP_W = $clog2(ROOT_BITS);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ROOT_BITS - 1);
   localparam int REM_W = ROOT_BITS + 2;
   localparam int ACC_W = ROOT_BITS + 4;

   logic [SUM_BITS-1:0]  rad_ff;
   logic [REM_W-1:0]     rem_ff;
   logic [ROOT_BITS-1:0] root_ff;
   logic [STEP_W-1:0]    step_ff;
   logic                 busy_ff;
   logic                 done_ff;

   logic [ACC_W-1:0] acc;
   logic [ACC_W-1:0] trial;
   logic [ACC_W-1:0] diff;
   logic             fits;

   assign acc   = {rem_ff, rad_ff[SUM_BITS-1 -: 2]};
   assign trial = {2'b00, root_ff, 2'b01};
   assign diff  = acc - trial;
   assign fits  = acc >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rad_ff  <= radicand;
            rem_ff  <= '0;
            root_ff <= '0;
            step_ff <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rad_ff  <= {rad_ff[SUM_BITS-3:0], 2'b00};
            root_ff <= {root_ff[ROOT_BITS-2:0], fits};
            rem_ff  <= fits ? diff[REM_W-1:0] : acc[REM_W-1:0];
            step_ff <= step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule

`default_nettype wire

[bench/lws_stats_checker.sv]
`timescale 1ns / 1ps

// Watches the three channels, keeps a shadow of the statistics and checks reports
module lws_stats_checker
   import lws_pkg::*;
(
   input  logic clock,
   input  logic reset,
   lws_req_if   req,
   lws_rsp_if   rsp,
   lws_csr_if   csr,
   output int   fail_count,
   output int   pending,
   output int   report_count
);

   localparam logic [63:0] LAT_MAX   = 64'hFF_FFFF;
   localparam logic [63:0] TIME_CEIL = 64'hFFFF_FFFF_FFFF;
   localparam logic [63:0] CNT_MAX   = 64'hFFFF_FFFF;
   localparam logic [63:0] SUM_MAX   = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic        kind;
      logic [31:0] count;
      logic [63:0] sum;
      logic [23:0] low;
      logic [23:0] high;
      logic [23:0] mean;
      logic [23:0] dev;
      logic        last;
   } report_type;

   report_type expected_reports[$];

   // shadow registers
   logic [63:0] cfg_count, cfg_period, cfg_start;
   // shadow statistics
   logic [63:0] win_n, win_sum, win_sq, win_lo, win_hi;
   logic [63:0] tot_n, tot_sum, tot_sq, tot_lo, tot_hi;
   logic [63:0] deadline;
   logic        running;

   assign pending = expected_reports.size();

   function automatic logic [63:0] sat_add(input logic [63:0] a, b, max);
      return (max - a < b) ? max : a + b;
   endfunction

   function automatic logic [63:0] int_root(input logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'h1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic report_type make_report(input logic kind, input logic [63:0] n, sum, sq,
                                              lo, hi);
      report_type rep;
      logic [63:0] mean, msq, m2, dev;
      mean = 0;
      dev = 0;
      if (n != 0) begin
         mean = sum / n;
         if (mean > LAT_MAX) mean = LAT_MAX;
         msq = sq / n;
         m2 = mean * mean;
         dev = (msq > m2) ? int_root(msq - m2) : 0;
         if (dev > LAT_MAX) dev = LAT_MAX;
      end else begin
         lo = 0;
         hi = 0;
      end
      rep.kind  = kind;
      rep.count = n[31:0];
      rep.sum   = sum;
      rep.low   = lo[23:0];
      rep.high  = hi[23:0];
      rep.mean  = mean[23:0];
      rep.dev   = dev[23:0];
      rep.last  = 1'b0;
      return rep;
   endfunction

   task automatic clear_window();
      win_n = 0; win_sum = 0; win_sq = 0; win_lo = LAT_MAX; win_hi = 0;
   endtask

   task automatic clear_run();
      clear_window();
      tot_n = 0; tot_sum = 0; tot_sq = 0; tot_lo = LAT_MAX; tot_hi = 0;
      deadline = 0;
      running = 1'b0;
   endtask

   task automatic fold_window();
      tot_n   = sat_add(tot_n, win_n, CNT_MAX);
      tot_sum = sat_add(tot_sum, win_sum, SUM_MAX);
      tot_sq  = sat_add(tot_sq, win_sq, SUM_MAX);
      if (win_lo < tot_lo) tot_lo = win_lo;
      if (win_hi > tot_hi) tot_hi = win_hi;
      clear_window();
   endtask

   // Update statistics for one accepted sample and queue the reports it causes
   task automatic take_sample(input logic [63:0] lat, input logic [63:0] next, input logic fin);
      report_type reps[$];
      logic [63:0] base;
      if (!running) begin
         deadline = sat_add(cfg_start, cfg_period, TIME_CEIL);
         running = 1'b1;
      end
      win_n   = sat_add(win_n, 1, CNT_MAX);
      win_sum = sat_add(win_sum, lat, SUM_MAX);
      win_sq  = sat_add(win_sq, lat * lat, SUM_MAX);
      if (lat < win_lo) win_lo = lat;
      if (lat > win_hi) win_hi = lat;
      if ((cfg_count != 0 && win_n >= cfg_count) || (cfg_period != 0 && next >= deadline)) begin
         reps.push_back(make_report(KIND_PERIOD, win_n, win_sum, win_sq, win_lo, win_hi));
         fold_window();
         if (cfg_period != 0 && next >= deadline) begin
            base = deadline + ((next - deadline) / cfg_period) * cfg_period;
            deadline = sat_add(base, cfg_period, TIME_CEIL);
         end
      end
      if (fin) begin
         fold_window();
         reps.push_back(make_report(KIND_TOTAL, tot_n, tot_sum, tot_sq, tot_lo, tot_hi));
         clear_run();
      end
      if (reps.size() > 0) reps[reps.size()-1].last = 1'b1;
      foreach (reps[i]) expected_reports.push_back(reps[i]);
   endtask

   task automatic check_field(input string name, input logic [63:0] want, got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // Sample every transfer at the rising edge
   always @(posedge clock) begin
      report_type want;
      if (reset) begin
         cfg_count = 0; cfg_period = 0; cfg_start = 0;
         clear_run();
         expected_reports.delete();
         fail_count = 0;
         report_count = 0;
      end else begin
         if (csr.valid && csr.ready) begin
            case (csr.index)
               CSR_PERIOD_COUNT:   cfg_count = {32'd0, csr.data[31:0]};
               CSR_PERIOD_TIME_US: cfg_period = {32'd0, csr.data[31:0]};
               CSR_START_TIME_US:  cfg_start = {16'd0, csr.data};
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            report_count++;
            if (expected_reports.size() == 0) begin
               $display("%0t ns: report transfer with none expected, expected none, actual %0h",
                        $time, rsp.latency_sum);
               fail_count++;
            end else begin
               want = expected_reports.pop_front();
               check_field("report_kind", want.kind, rsp.report_kind);
               check_field("sample_count", want.count, rsp.sample_count);
               check_field("latency_sum", want.sum, rsp.latency_sum);
               check_field("latency_min", want.low, rsp.latency_min);
               check_field("latency_max", want.high, rsp.latency_max);
               check_field("latency_mean", want.mean, rsp.latency_mean);
               check_field("latency_dev", want.dev, rsp.latency_dev);
               check_field("last_of_run", want.last, rsp.last_of_run);
            end
         end
         if (req.valid && req.ready)
            take_sample({40'd0, req.latency_us}, {16'd0, req.next_time_us}, req.final_req);
      end
   end

endmodule

[bench/latency_window_statistics_top_test.sv]
`timescale 1ns / 1ps

module latency_window_statistics_top_test;
   import lws_pkg::*;

   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int PHASE_ITEMS = 150;
   localparam int NUM_PHASES  = 7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, pending, report_count;
   int   cycle_count = 0;
   int   sample_total = 0;
   logic calm = 1'b0;       // no idling on either side
   logic hold_request = 1'b0;
   logic [47:0] now_us;

   lws_req_if #(.LAT_W(24), .TIME_W(48)) req_bus ();
   lws_rsp_if #(.LAT_W(24)) rsp_bus ();
   lws_csr_if csr_bus ();

   latency_window_statistics_top #(.LATENCY_BITS(24), .TIME_BITS(48)) dut (
      .clock(clock), .reset(reset),
      .req_chan(req_bus), .rsp_chan(rsp_bus), .csr_chan(csr_bus)
   );

   lws_stats_checker u_checker (
      .clock(clock), .reset(reset),
      .req(req_bus), .rsp(rsp_bus), .csr(csr_bus),
      .fail_count(fail_count), .pending(pending), .report_count(report_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Report side: random stall bursts, plus one long hold-off on request
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_bus.ready = 1'b0;
            repeat (3000) @(negedge clock);
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end else begin
            rsp_bus.ready = 1'b1;
         end
      end
   end

   task automatic write_reg(input csr_index_type idx, input logic [47:0] value);
      @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data  = value;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // One sample transfer; valid stays high unless a gap follows
   task automatic send_sample(input logic [23:0] lat, input logic [47:0] next, input logic fin);
      req_bus.valid        = 1'b1;
      req_bus.latency_us   = lat;
      req_bus.next_time_us = next;
      req_bus.final_req    = fin;
      do @(posedge clock); while (!req_bus.ready);
      sample_total++;
      @(negedge clock);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
   endtask

   // Drain reports, then let an in-flight sample with no report finish
   task automatic settle();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic configure(input logic [31:0] count, period, input logic [47:0] start);
      write_reg(CSR_PERIOD_COUNT, {16'd0, count});
      write_reg(CSR_PERIOD_TIME_US, {16'd0, period});
      write_reg(CSR_START_TIME_US, start);
   endtask

   function automatic logic [23:0] pick_latency();
      case ($urandom_range(0, 29))
         0:       return 24'hFF_FFFF;
         1:       return 24'd0;
         2, 3, 4: return 24'($urandom);
         default: return 24'($urandom_range(0, 5000));
      endcase
   endfunction

   logic [31:0] phase_count  [NUM_PHASES] = '{1, 7, 0, 5, 0, 32'hFFFF_FFFF, 3};
   logic [31:0] phase_period [NUM_PHASES] = '{0, 0, 100, 250, 0, 32'hFFFF_FFFF, 1};
   logic [47:0] phase_start  [NUM_PHASES] =
      '{0, 0, 0, 1000, 0, 48'hFFFF_FFFF_F000, 0};
   int          phase_step   [NUM_PHASES] = '{10, 10, 60, 100, 10, 50000, 5};
   int          phase_finals [NUM_PHASES] = '{40, 40, 40, 30, 8, 40, 40};

   initial begin
      logic [47:0] next;
      logic        fin;
      req_bus.valid = 1'b0;
      req_bus.latency_us = '0;
      req_bus.next_time_us = '0;
      req_bus.final_req = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_PERIOD_COUNT;
      csr_bus.data = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: reset settings, field extremes, lone final, back-to-back finals
      send_sample(24'd0, 48'd0, 1'b1);
      send_sample(24'hFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1);
      send_sample(24'hFF_FFFF, 48'd5, 1'b0);
      send_sample(24'd0, 48'd6, 1'b0);
      send_sample(24'h80_0001, 48'h8000_0000_0000, 1'b1);
      settle();
      // count-based closes, one closing on a final sample
      configure(32'd2, 32'd0, 48'd0);
      send_sample(24'd3, 48'd1, 1'b0);
      send_sample(24'd9, 48'd2, 1'b0);
      send_sample(24'd4, 48'd3, 1'b0);
      send_sample(24'd8, 48'd4, 1'b1);
      settle();
      // time-based: deadline 110, jump several periods, then the largest time
      configure(32'd0, 32'd10, 48'd100);
      send_sample(24'd7, 48'd109, 1'b0);
      send_sample(24'd7, 48'd110, 1'b0);
      send_sample(24'd1, 48'd175, 1'b0);
      send_sample(24'd2, 48'hFFFF_FFFF_FFFF, 1'b0);
      send_sample(24'd3, 48'hFFFF_FFFF_FFFF, 1'b1);
      settle();

      // Random phases under several settings
      for (int p = 0; p < NUM_PHASES; p++) begin
         configure(phase_count[p], phase_period[p], phase_start[p]);
         calm = (p == NUM_PHASES - 1);
         if (p == 1) hold_request = 1'b1;
         now_us = phase_start[p];
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if ($urandom_range(0, 49) == 0) next = 48'({$urandom, $urandom});
            else begin
               now_us = now_us + 48'($urandom_range(0, phase_step[p]));
               next = now_us;
            end
            fin = (i == PHASE_ITEMS - 1) || ($urandom_range(0, phase_finals[p] - 1) == 0);
            send_sample(pick_latency(), next, fin);
         end
         settle();
      end

      repeat (500) @(negedge clock);
      $display("%0d samples sent over %0d settings, %0d reports checked",
               sample_total, NUM_PHASES + 3, report_count);
      $display("covered count and time closes, saturated deadlines, finals and a long stall");
      if (fail_count == 0 && pending == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches, %0d reports missing", fail_count, pending);
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

[sim.f]
src/lws_pkg.sv
src/lws_req_if.sv
src/lws_rsp_if.sv
src/lws_csr_if.sv
src/lws_div.sv
src/lws_sqrt.sv
src/latency_window_statistics_top.sv
bench/lws_stats_checker.sv
bench/latency_window_statistics_top_test.sv
